@@ sv/log_history_ring_with_reader_assert.svh @@
// Assertion macros used by the port-level checker of the history ring.
`ifndef LOG_HISTORY_RING_WITH_READER_ASSERT_SVH
`define LOG_HISTORY_RING_WITH_READER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LHR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LHR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/lhr_pkg.sv @@
// Package: widths, codes, defaults and state type of the history ring.
package lhr_pkg;

    localparam int RING_DEPTH_DEF = 4096;
    localparam int MAX_CHUNK_DEF  = 64;

    localparam int BYTE_W = 8;
    localparam int CNT_W  = 7;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

    localparam logic CMD_LOG  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NL,
        ST_READ
    } t_state;

endpackage

@@ sv/lhr_if.sv @@
// Channel interfaces: log/read requests in, history words out.
interface lhr_in_if;
    import lhr_pkg::*;

    logic              valid;
    logic              ready;
    logic              cmd;
    logic [BYTE_W-1:0] log_byte;
    logic              msg_first;
    logic              msg_last;
    logic [CNT_W-1:0]  read_count;

    modport source (output valid, output cmd, output log_byte, output msg_first,
                    output msg_last, output read_count, input ready);
    modport sink   (input valid, input cmd, input log_byte, input msg_first,
                    input msg_last, input read_count, output ready);
endinterface

interface lhr_out_if;
    import lhr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              empty_res;
    logic              read_last;

    modport source (output valid, output out_byte, output empty_res, output read_last,
                    input ready);
    modport sink   (input valid, input out_byte, input empty_res, input read_last,
                    output ready);
endinterface

@@ sv/lhr_hist_ram.sv @@
// History byte store: one write port, one registered read port.
module lhr_hist_ram #(
    parameter int DEPTH = lhr_pkg::RING_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [lhr_pkg::BYTE_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [lhr_pkg::BYTE_W-1:0] o_rd_data
);
    import lhr_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/log_history_ring_with_reader.sv @@
// Top level: overwriting byte history ring with one reader cursor.
//
//  channel   dir   handshake          payload
//  i_in      in    valid/ready        cmd, log_byte, msg_first, msg_last, read_count
//  o_out     out   valid/ready        out_byte, empty_res, read_last
//
//  Log word: a trailing newline, when appended, is a second RAM write from ST_NL.
//  Read word: bytes pass the RAM read register and then the output register to o_out,
//  one byte per cycle while the sink holds ready, paced by the single RAM read port.
//  Empty read: the empty word enters the output register from ST_READ once it is free.
//  Reset clears state, head, counters and valid flags only; the RAM needs no clearing pass.
//  A new word is taken as soon as the last result of a read sits in the output register.
module log_history_ring_with_reader #(
    parameter int RING_DEPTH = lhr_pkg::RING_DEPTH_DEF,
    parameter int MAX_CHUNK  = lhr_pkg::MAX_CHUNK_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lhr_in_if.sink      i_in,
    lhr_out_if.source   o_out
);
    import lhr_pkg::*;

    localparam int AW  = $clog2(RING_DEPTH);
    localparam int BW  = $clog2(RING_DEPTH + 1);
    localparam int XW  = (BW > CNT_W) ? BW : CNT_W;
    localparam int SW  = AW + 1;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_head, n_head;
    logic [BW-1:0]     r_behind, n_behind;
    logic [AW-1:0]     r_rd_addr, n_rd_addr;
    logic [CNT_W-1:0]  r_left, n_left;
    logic              r_empty, n_empty;
    logic              r_rd_valid, n_rd_valid;
    logic              r_rd_last, n_rd_last;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_out_empty, n_out_empty;
    logic              r_out_last, n_out_last;

    logic              w_in_acc;
    logic [CNT_W-1:0]  w_cnt;
    logic [CNT_W-1:0]  w_want;
    logic [SW-1:0]     w_sum;
    logic [AW-1:0]     w_start;
    logic [AW-1:0]     w_head_inc;
    logic [BW-1:0]     w_behind_inc;
    logic [AW-1:0]     w_addr_inc;
    logic              w_out_free;
    logic              w_move;
    logic              w_issue;
    logic              w_wr_en;
    logic [BYTE_W-1:0] w_wr_data;
    logic [BYTE_W-1:0] w_rd_data;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in.valid & i_in.ready;

    // Clip the request, then take no more than is unread.
    assign w_cnt  = (i_in.read_count > CNT_W'(MAX_CHUNK)) ? CNT_W'(MAX_CHUNK)
                                                          : i_in.read_count;
    assign w_want = (XW'(r_behind) > XW'(w_cnt)) ? w_cnt : CNT_W'(r_behind);

    // Oldest unread slot: head minus backlog, modulo the ring depth.
    assign w_sum   = SW'(r_head) + SW'(RING_DEPTH) - SW'(r_behind);
    assign w_start = (w_sum >= SW'(RING_DEPTH)) ? AW'(w_sum - SW'(RING_DEPTH))
                                                : AW'(w_sum);

    assign w_head_inc   = (r_head == AW'(RING_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_behind_inc = (r_behind == BW'(RING_DEPTH)) ? r_behind : r_behind + 1'b1;
    assign w_addr_inc   = (r_rd_addr == AW'(RING_DEPTH - 1)) ? '0 : r_rd_addr + 1'b1;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_move     = r_rd_valid && w_out_free;
    assign w_issue    = (r_state == ST_READ) && !r_empty && (r_left != '0)
                        && (!r_rd_valid || w_move);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_behind    = r_behind;
        n_rd_addr   = r_rd_addr;
        n_left      = r_left;
        n_empty     = r_empty;
        n_rd_valid  = r_rd_valid;
        n_rd_last   = r_rd_last;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_empty = r_out_empty;
        n_out_last  = r_out_last;
        w_wr_en     = 1'b0;
        w_wr_data   = i_in.log_byte;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.cmd == CMD_LOG) begin
                        // drop the header byte of each message
                        if (!i_in.msg_first) begin
                            w_wr_en  = 1'b1;
                            n_head   = w_head_inc;
                            n_behind = w_behind_inc;
                            if (i_in.msg_last && (i_in.log_byte != NEWLINE_BYTE)) begin
                                n_state = ST_NL;
                            end
                        end
                    end else begin
                        n_behind  = r_behind - BW'(w_want);
                        n_rd_addr = w_start;
                        n_left    = w_want;
                        n_empty   = (w_want == '0);
                        n_state   = ST_READ;
                    end
                end
            end
            ST_NL: begin
                w_wr_en   = 1'b1;
                w_wr_data = NEWLINE_BYTE;
                n_head    = w_head_inc;
                n_behind  = w_behind_inc;
                n_state   = ST_IDLE;
            end
            ST_READ: begin
                if (r_empty) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out_byte  = '0;
                        n_out_empty = 1'b1;
                        n_out_last  = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end else begin
                    if (w_move) begin
                        n_out_valid = 1'b1;
                        n_out_byte  = w_rd_data;
                        n_out_empty = 1'b0;
                        n_out_last  = r_rd_last;
                        n_rd_valid  = 1'b0;
                        if (r_rd_last) begin
                            n_state = ST_IDLE;
                        end
                    end
                    if (w_issue) begin
                        n_rd_valid = 1'b1;
                        n_rd_last  = (r_left == CNT_W'(1));
                        n_rd_addr  = w_addr_inc;
                        n_left     = r_left - 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_behind    <= '0;
            r_left      <= '0;
            r_empty     <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_behind    <= n_behind;
            r_left      <= n_left;
            r_empty     <= n_empty;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr   <= n_rd_addr;
        r_rd_last   <= n_rd_last;
        r_out_byte  <= n_out_byte;
        r_out_empty <= n_out_empty;
        r_out_last  <= n_out_last;
    end

    lhr_hist_ram #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_hist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_head),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign o_out.valid     = r_out_valid;
    assign o_out.out_byte  = r_out_byte;
    assign o_out.empty_res = r_out_empty;
    assign o_out.read_last = r_out_last;

endmodule

@@ sv/lhr_checker.sv @@
// Port-level checker for the history ring, bound to the top level.
`include "log_history_ring_with_reader_assert.svh"

module lhr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_cmd,
    input logic [lhr_pkg::BYTE_W-1:0] i_log_byte,
    input logic                       i_msg_first,
    input logic                       i_msg_last,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [lhr_pkg::BYTE_W-1:0] i_out_byte,
    input logic                       i_empty_res,
    input logic                       i_read_last
);
    import lhr_pkg::*;

    logic       w_in_acc;
    logic       w_rd_acc;
    logic       w_out_done;
    logic       w_nl_due;
    logic [1:0] r_pend, n_pend;

    assign w_in_acc   = i_in_valid && i_in_ready;
    assign w_rd_acc   = w_in_acc && (i_cmd == CMD_READ);
    assign w_out_done = i_out_valid && i_out_ready && i_read_last;
    assign w_nl_due   = w_in_acc && (i_cmd == CMD_LOG) && !i_msg_first && i_msg_last
                        && (i_log_byte != NEWLINE_BYTE);

    // Reads accepted whose final word has not yet been taken.
    always_comb begin
        n_pend = r_pend + {1'b0, w_rd_acc} - {1'b0, w_out_done};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    `LHR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte) && $stable(i_empty_res) && $stable(i_read_last), "output word changed while stalled")
    `LHR_ASSERT_IMP(a_out_owed, i_clk, i_rst_n, i_out_valid && i_out_ready, r_pend != 2'd0, "output word with no read outstanding")
    `LHR_ASSERT_IMP(a_rd_depth, i_clk, i_rst_n, w_in_acc, r_pend != 2'd2, "word taken while a read still streams")
    `LHR_ASSERT_NXT(a_nl_slot, i_clk, i_rst_n, w_nl_due, !i_in_ready, "no cycle left for the trailing newline")

endmodule

bind log_history_ring_with_reader lhr_checker u_lhr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_cmd       (i_in.cmd),
    .i_log_byte  (i_in.log_byte),
    .i_msg_first (i_in.msg_first),
    .i_msg_last  (i_in.msg_last),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_empty_res (o_out.empty_res),
    .i_read_last (o_out.read_last)
);

@@ tb/lhr_checker.sv @@
// Checker: predicts the history ring's reads from accepted words and compares every result.
`timescale 1ns / 1ps
module lhr_tb_checker #(
    parameter int RING_DEPTH = lhr_pkg::RING_DEPTH_DEF,
    parameter int MAX_CHUNK  = lhr_pkg::MAX_CHUNK_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lhr_in_if    i_req,
    lhr_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);
    import lhr_pkg::*;

    localparam int HEAD_W = $clog2(RING_DEPTH);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              empty;
        logic              fin;
    } t_hist_res;

    logic [BYTE_W-1:0] ring_copy [RING_DEPTH];
    logic [HEAD_W-1:0] head;
    logic [63:0]       total;
    logic [63:0]       cursor;
    t_hist_res         due_bytes [$];
    int                errors = 0;

    function automatic void push_history(logic [BYTE_W-1:0] value);
        ring_copy[head] = value;
        head  = head + 1'b1;
        total = total + 64'd1;
    endfunction

    // Queue the bytes (or the empty word) a read request hands out and advance the cursor past them.
    task automatic predict_read(logic [CNT_W-1:0] asked);
        logic [63:0]       lag;
        logic [63:0]       grant;
        logic [HEAD_W-1:0] slot;
        grant = (asked > MAX_CHUNK) ? 64'(MAX_CHUNK) : 64'(asked);
        if (cursor > total) begin
            cursor = total;
        end
        lag = total - cursor;
        // reader overrun: skip to the oldest byte still held
        if (lag > 64'(RING_DEPTH)) begin
            cursor = total - 64'(RING_DEPTH);
            lag    = 64'(RING_DEPTH);
        end
        if (lag < grant) begin
            grant = lag;
        end
        if (grant == 64'd0) begin
            due_bytes.push_back('{data: '0, empty: 1'b1, fin: 1'b1});
        end else begin
            slot = head - lag[HEAD_W-1:0];
            for (int i = 0; i < int'(grant); i++) begin
                due_bytes.push_back('{data: ring_copy[slot], empty: 1'b0,
                                      fin: (i + 1 == int'(grant))});
                slot = slot + 1'b1;
            end
            cursor = cursor + grant;
        end
    endtask

    task automatic report_mismatch(string what, logic [BYTE_W-1:0] got,
                                   logic [BYTE_W-1:0] want);
        $display("%0t: mismatch on %s: got %02h, want %02h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_hist_res due;
        if (!i_rst_n) begin
            head   = '0;
            total  = '0;
            cursor = '0;
            due_bytes.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (due_bytes.size() == 0) begin
                    report_mismatch("result with nothing due", i_res.out_byte, '0);
                end else begin
                    due = due_bytes.pop_front();
                    if (i_res.out_byte !== due.data) begin
                        report_mismatch("out_byte", i_res.out_byte, due.data);
                    end
                    if (i_res.empty_res !== due.empty) begin
                        report_mismatch("empty_res", 8'(i_res.empty_res), 8'(due.empty));
                    end
                    if (i_res.read_last !== due.fin) begin
                        report_mismatch("read_last", 8'(i_res.read_last), 8'(due.fin));
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                if (i_req.cmd == CMD_READ) begin
                    predict_read(i_req.read_count);
                end else if (!i_req.msg_first) begin
                    // drop headers; close a message with a newline unless it ends in one
                    push_history(i_req.log_byte);
                    if (i_req.msg_last && i_req.log_byte != NEWLINE_BYTE) begin
                        push_history(NEWLINE_BYTE);
                    end
                end
            end
        end
        o_fail_count <= errors;
        o_pending    <= due_bytes.size();
    end

endmodule

@@ tb/tb.sv @@
// Testbench top: log and read stimulus, output stalls, watchdog and verdict for the history ring.
`timescale 1ns / 1ps
module tb;
    import lhr_pkg::*;

    localparam int HOLD_CYCLES  = 200;
    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_WORDS = 80;
    localparam int FLOOD_BYTES  = 24;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    bit   src_gapless;
    bit   hold_out;

    lhr_in_if  in_ch ();
    lhr_out_if out_ch ();

    log_history_ring_with_reader dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    lhr_tb_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (in_ch),
        .i_res        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Half the time no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_log_byte();
        if ($urandom_range(0, 5) == 0) begin
            return NEWLINE_BYTE;
        end
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic send_word(logic cmd, logic [BYTE_W-1:0] value, logic first, logic fin,
                             logic [CNT_W-1:0] count);
        int gap;
        gap = src_gapless ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= cmd;
        in_ch.log_byte   <= value;
        in_ch.msg_first  <= first;
        in_ch.msg_last   <= fin;
        in_ch.read_count <= count;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    task automatic send_log(logic [BYTE_W-1:0] value, logic first, logic fin);
        send_word(CMD_LOG, value, first, fin, CNT_W'($urandom));
    endtask

    task automatic send_read(logic [CNT_W-1:0] count);
        send_word(CMD_READ, BYTE_W'($urandom), 1'($urandom), 1'($urandom), count);
    endtask

    // Header plus body; an empty body makes a header-only message.
    task automatic send_message(int body_len, inout int stored);
        logic [BYTE_W-1:0] value;
        send_log(rand_log_byte(), 1'b1, body_len == 0);
        for (int i = 0; i < body_len; i++) begin
            value = rand_log_byte();
            send_log(value, 1'b0, i == body_len - 1);
            stored += (i == body_len - 1 && value != NEWLINE_BYTE) ? 2 : 1;
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin : result_sink
        int gap;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_out) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_out = 1'b0;
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int stored;
        int words;
        int pick;
        int body;
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.cmd        <= CMD_LOG;
        in_ch.log_byte   <= '0;
        in_ch.msg_first  <= 1'b0;
        in_ch.msg_last   <= 1'b0;
        in_ch.read_count <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty ring: both give the empty word
        send_read(CNT_W'(5));
        send_read('0);
        // header dropped, body stored, newline appended after a non-newline end
        send_log(8'hFF, 1'b1, 1'b0);
        send_log(8'h00, 1'b0, 1'b0);
        send_log(8'hFF, 1'b0, 1'b0);
        send_log(NEWLINE_BYTE, 1'b0, 1'b0);
        send_log(8'h41, 1'b0, 1'b1);
        // message already ending in a newline
        send_log(8'h80, 1'b1, 1'b0);
        send_log(8'h55, 1'b0, 1'b0);
        send_log(NEWLINE_BYTE, 1'b0, 1'b1);
        // header-only message stores nothing
        send_log(8'h33, 1'b1, 1'b1);
        // bytes with no header before them
        send_log(8'hAA, 1'b0, 1'b0);
        send_log(8'h5A, 1'b0, 1'b1);
        send_read('0);
        send_read('1);
        send_read(CNT_W'(3));
        send_log(8'h01, 1'b0, 1'b1);
        send_log(8'h02, 1'b0, 1'b0);
        send_read(CNT_W'(1));
        send_read(CNT_W'(64));
        send_read(CNT_W'(65));
        wait_drained();

        // store a gapless burst of messages with no reads, then read it back
        stored      = 0;
        src_gapless = 1'b1;
        while (stored < FLOOD_BYTES) begin
            send_message($urandom_range(0, 12), stored);
        end
        src_gapless = 1'b0;
        send_read(CNT_W'(64));
        send_read(CNT_W'(64));

        // hold the receiver off while reads keep coming, so the block backs up
        hold_out = 1'b1;
        repeat (10) send_read(CNT_W'(64));
        wait_drained();

        words = 0;
        while (words < RANDOM_WORDS) begin
            src_gapless = ($urandom_range(0, 3) == 0);
            pick        = $urandom_range(0, 19);
            if (pick < 9) begin
                body = $urandom_range(0, 8);
                send_message(body, stored);
                words += body + 1;
            end else if (pick < 16) begin
                send_read(CNT_W'($urandom_range(0, 70)));
                words++;
            end else if (pick < 17) begin
                send_read(CNT_W'($urandom_range(65, 127)));
                words++;
            end else if (pick < 19) begin
                send_log(BYTE_W'($urandom), 1'($urandom), 1'($urandom));
                words++;
            end else begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/lhr_pkg.sv
sv/lhr_if.sv
sv/lhr_hist_ram.sv
sv/log_history_ring_with_reader.sv
sv/lhr_checker.sv
tb/lhr_checker.sv
tb/tb.sv
